### rtl/assert_macros.svh
// Assertion helpers for the RTL file that carries checks.
// Every check is sampled on the rising edge of clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/scrc_pkg.sv
`default_nettype none

package scrc_pkg;

    // Code select values
    localparam logic [2:0] CODE_CRC32_EE5B = 3'd1;
    localparam logic [2:0] CODE_CRC32C     = 3'd2;
    localparam logic [2:0] CODE_KERMIT     = 3'd3;
    localparam logic [2:0] CODE_ARC        = 3'd4;
    localparam logic [2:0] CODE_RESET      = CODE_CRC32_EE5B;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_CODE_TYPE = 3'd0;

    // Polynomials; reflected codes hold the bit-reversed form
    localparam logic [31:0] POLY_EE5B      = 32'hEE5B42FD;
    localparam logic [31:0] POLY_CRC32C_R  = 32'h82F63B78;  // 0x1EDC6F41 reversed
    localparam logic [31:0] POLY_KERMIT_R  = 32'h00008408;  // 0x1021 reversed
    localparam logic [31:0] POLY_ARC_R     = 32'h0000A001;  // 0x8005 reversed
    localparam logic [31:0] MASK_32        = 32'hFFFFFFFF;
    localparam logic [31:0] MASK_16        = 32'h0000FFFF;

    typedef struct packed {
        logic [31:0] width_mask;
        logic [31:0] poly;
        logic [31:0] init;
        logic [31:0] xor_out;
        logic        reflected;
    } crc_code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [2:0] code_type;  // current selection
        logic       wr_en;      // register written this cycle
        logic [2:0] wr_code;    // value being written
    } cfg_t;

    // Code parameters; undefined selections behave as the first code
    function automatic crc_code_t code_params(input logic [2:0] sel);
        crc_code_t c;
        unique case (sel)
            CODE_CRC32C: c = '{MASK_32, POLY_CRC32C_R, MASK_32, MASK_32, 1'b1};
            CODE_KERMIT: c = '{MASK_16, POLY_KERMIT_R, 32'h0, 32'h0, 1'b1};
            CODE_ARC:    c = '{MASK_16, POLY_ARC_R, 32'h0, 32'h0, 1'b1};
            default:     c = '{MASK_32, POLY_EE5B, 32'h0, 32'h0, 1'b0};
        endcase
        return c;
    endfunction

    // One byte through the CRC register: eight shift/xor steps
    function automatic logic [31:0] crc_byte_update(
        input crc_code_t   c,
        input logic [31:0] crc,
        input logic [7:0]  b
    );
        logic [31:0] v;
        int          i;
        if (c.reflected)
        begin
            v = crc ^ {24'h0, b};
            for (i = 0; i < 8; i++)
            begin
                v = v[0] ? ((v >> 1) ^ c.poly) : (v >> 1);
            end
        end
        else
        begin
            v = crc ^ {b, 24'h0};
            for (i = 0; i < 8; i++)
            begin
                v = v[31] ? ((v << 1) ^ c.poly) : (v << 1);
            end
        end
        return v & c.width_mask;
    endfunction

endpackage

`default_nettype wire

### rtl/scrc_if.sv
`default_nettype none

// Byte stream channel
interface scrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Finished CRC channel
interface scrc_crc_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

### rtl/scrc_apb.sv
`default_nettype none

module scrc_apb (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [scrc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output scrc_pkg::cfg_t                        cfg
);

    logic [2:0] code_type_reg;
    logic [2:0] code_type_next;
    logic       wr_hit;

    assign pready = 1'b1;

    // Write strobe for the code select register
    assign wr_hit = psel && penable && pwrite && (paddr == scrc_pkg::ADDR_CODE_TYPE);

    always_comb
    begin
        code_type_next = code_type_reg;
        if (wr_hit)
        begin
            code_type_next = pwdata[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_type_reg <= scrc_pkg::CODE_RESET;
        end
        else
        begin
            code_type_reg <= code_type_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = 32'h0;
        if (paddr == scrc_pkg::ADDR_CODE_TYPE)
        begin
            prdata = {29'h0, code_type_reg};
        end
    end

    assign cfg.code_type = code_type_reg;
    assign cfg.wr_en     = wr_hit;
    assign cfg.wr_code   = pwdata[2:0];

endmodule

`default_nettype wire

### rtl/scrc_in_stage.sv
`default_nettype none

module scrc_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    scrc_byte_if.sink            data_ch,
    input  wire logic            advance,
    output logic                 item_valid,
    output scrc_pkg::item_t      item
);

    logic            valid_reg;
    logic            valid_next;
    scrc_pkg::item_t item_reg;
    logic            take;

    // Stage frees up whenever the held byte moves on this cycle
    assign data_ch.ready = !valid_reg || advance;
    assign take          = data_ch.valid && data_ch.ready;

    always_comb
    begin
        priority if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{data_byte: data_ch.data_byte, last_byte: data_ch.last_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### rtl/scrc_core.sv
`default_nettype none

module scrc_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire scrc_pkg::cfg_t  cfg,
    input  wire logic            item_valid,
    input  wire scrc_pkg::item_t item,
    output logic                 advance,
    scrc_crc_if.source           crc_ch
);

    scrc_pkg::crc_code_t code;
    scrc_pkg::crc_code_t wr_code;
    logic [31:0]         updated;
    logic [31:0]         running_crc_reg;
    logic [31:0]         running_crc_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [31:0]         crc_out_reg;
    logic                finish;

    assign code    = scrc_pkg::code_params(cfg.code_type);
    assign wr_code = scrc_pkg::code_params(cfg.wr_code);
    assign updated = scrc_pkg::crc_byte_update(code, running_crc_reg, item.data_byte);

    // A non-final byte always moves; a final one needs the result register free
    assign advance = item_valid && (!item.last_byte || !out_valid_reg || crc_ch.ready);
    assign finish  = advance && item.last_byte;

    // Running CRC
    always_comb
    begin
        priority if (cfg.wr_en)
        begin
            running_crc_next = wr_code.init;
        end
        else if (finish)
        begin
            running_crc_next = code.init;
        end
        else if (advance)
        begin
            running_crc_next = updated;
        end
        else
        begin
            running_crc_next = running_crc_reg;
        end
    end

    // Result register handshake
    always_comb
    begin
        priority if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (crc_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= 32'h0;   // init of the reset code
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            crc_out_reg <= (updated ^ code.xor_out) & code.width_mask;
        end
    end

    assign crc_ch.valid     = out_valid_reg;
    assign crc_ch.crc_value = crc_out_reg;

endmodule

`default_nettype wire

### rtl/selectable_crc_engine_top.sv
// Selectable CRC engine: byte-wide CRC over a message, code chosen by register.
// data_ch carries one message byte per transfer; last_byte marks the final byte.
// crc_ch carries one finished CRC per message, taken on the transfer of the last
// byte; 16-bit codes return zeros in the upper half.
// The APB port holds code_type at address 0 (1: 0xEE5B42FD, 2: CRC-32C,
// 3: KERMIT, 4: ARC; other values act as 1). Every write to code_type restarts the message.
// Throughput: one byte per cycle while no final byte waits on a stalled crc_ch.
// Each byte goes into an input register, from which the eight-step xor network updates
// the running CRC; for the last byte the update goes to the result register and the CRC restarts.
// A stalled crc_ch holds its result; non-final bytes keep flowing, and only a
// further final byte waits in the input register, which then drops ready.
// Reset: code 1 selected, running CRC zero, both stages empty.
`default_nettype none
`include "assert_macros.svh"

module selectable_crc_engine_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [scrc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    scrc_byte_if.sink                             data_ch,
    scrc_crc_if.source                            crc_ch
);

    scrc_pkg::cfg_t  cfg;
    scrc_pkg::item_t item;
    logic            item_valid;
    logic            advance;
    logic            narrow_code;
    logic            last_held;

    scrc_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scrc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_ch    (data_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    scrc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .crc_ch     (crc_ch)
    );

    // Check terms
    assign narrow_code = (cfg.code_type == scrc_pkg::CODE_KERMIT)
                      || (cfg.code_type == scrc_pkg::CODE_ARC);
    assign last_held   = item_valid && item.last_byte;

    // Checks
    `ASSERT_IMPL(a_narrow_upper_zero, crc_ch.valid && narrow_code, crc_ch.crc_value[31:16] == 16'h0, "16-bit result has upper bits set")
    `ASSERT_IMPL(a_result_from_last, $rose(crc_ch.valid), $past(last_held), "result without a final byte")
    `ASSERT_NEXT(a_transfer_lands, data_ch.valid && data_ch.ready, item_valid, "accepted byte not held")

endmodule

`default_nettype wire
